### hdl/itt_pkg.sv
// ----------------------------------------------------------------------------
// itt_pkg
// Shared types and constants for the interval / timeout timer: the item
// structs of both channels, command codes, register indexes and FSM states.
// ----------------------------------------------------------------------------
package itt_pkg;

  // Default width of the internal time arithmetic.
  localparam int TIME_WIDTH_DEF = 32;

  // Widths of the item fields and of the configuration port.
  localparam int CMD_W  = 3;
  localparam int NOW_W  = 32;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 32;

  // Command codes carried in an input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_POLL   = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_RESUME = 3'd3,
    CMD_ORIGIN = 3'd4
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IW-1:0] {
    CFG_INTERVAL = 2'd0,
    CFG_PERIODIC = 2'd1,
    CFG_FIRE     = 2'd2
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADJ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [NOW_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic ready_res;
    logic enabled;
  } out_item_t;

endpackage

### hdl/interval_timeout_timer.sv
// ----------------------------------------------------------------------------
// interval_timeout_timer
// Interval / timeout timer with catch-up over missed periods.
// ----------------------------------------------------------------------------
// Every item returns exactly one result. Start, stop, resume, origin reset,
// unknown commands and most polls finish at the accepting edge, so their
// result is registered there and shows in the next cycle. A periodic poll
// that fires after more than one period has gone by needs the remainder of
// the overdue time by the interval; one subtract-and-compare unit forms it
// one bit per cycle, so such a poll passes through the accepting cycle,
// TIME_WIDTH division steps, one adjust step and a commit step that waits
// for a free output register. The input is stalled while a poll is being
// resolved and while a finished result waits and is held off.
// ----------------------------------------------------------------------------
module interval_timeout_timer
  import itt_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input item channel
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  // Result item channel
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  // Configuration write port
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int TW = TIME_WIDTH;
  localparam int CW = $clog2(TW);

  // Configuration registers.
  logic [CFG_DW-1:0] interval_r;
  logic              periodic_r;
  logic              fire_r;

  // Timer state.
  logic              running_r,  running_nxt;
  logic              just_r,     just_nxt;
  logic [TW-1:0]     origin_r,   origin_nxt;
  logic [TW-1:0]     paused_r,   paused_nxt;

  // Sequencer and division datapath.
  state_t            state_r,    state_nxt;
  logic [CW-1:0]     cnt_r,      cnt_nxt;
  logic [TW-1:0]     dvd_r,      dvd_nxt;
  logic [TW-1:0]     rem_r,      rem_nxt;
  logic [TW-1:0]     tgt_r,      tgt_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r,  out_data_nxt;

  // Time-width views of the interval and the timestamp.
  logic [TW+CFG_DW-1:0] iv_ext;
  logic [TW+NOW_W-1:0]  now_ext;
  logic [TW-1:0]        iv_t;
  logic [TW-1:0]        now_t;
  logic [TW-1:0]        elapsed;
  logic [TW-1:0]        target;
  logic [TW:0]          shifted;
  logic                 accept;
  logic                 out_free;

  assign iv_ext  = {{TW{1'b0}}, interval_r};
  assign now_ext = {{TW{1'b0}}, in_data.now};
  assign iv_t    = iv_ext[TW-1:0];
  assign now_t   = now_ext[TW-1:0];
  assign elapsed = now_t - origin_r;
  assign target  = now_t - iv_t;
  assign shifted = {rem_r, dvd_r[TW-1]};

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= CFG_DW'(1);
      periodic_r <= 1'b1;
      fire_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTERVAL: interval_r <= cfg_data;
        CFG_PERIODIC: periodic_r <= cfg_data[0];
        CFG_FIRE:     fire_r     <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      running_r   <= 1'b0;
      just_r      <= 1'b0;
      origin_r    <= '0;
      paused_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      just_r      <= just_nxt;
      origin_r    <= origin_nxt;
      paused_r    <= paused_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    tgt_r      <= tgt_nxt;
    out_data_r <= out_data_nxt;
  end

  // Command handling and the catch-up sequencer.
  always_comb begin
    state_nxt     = state_r;
    running_nxt   = running_r;
    just_nxt      = just_r;
    origin_nxt    = origin_r;
    paused_nxt    = paused_r;
    cnt_nxt       = cnt_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    tgt_nxt       = tgt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.ready_res = 1'b0;
          case (in_data.command)
            CMD_POLL: begin
              if (!running_r) begin
                out_data_nxt.ready_res = 1'b0;
              end else if (just_r && periodic_r) begin
                just_nxt               = 1'b0;
                out_data_nxt.ready_res = 1'b1;
              end else if (elapsed < iv_t) begin
                out_data_nxt.ready_res = 1'b0;
              end else if (!periodic_r) begin
                running_nxt            = 1'b0;
                out_data_nxt.ready_res = 1'b1;
              end else if (iv_t == '0) begin
                out_data_nxt.ready_res = 1'b1;
              end else if (target > origin_r) begin
                // Several periods overdue: resolve the remainder first.
                out_valid_nxt = 1'b0;
                tgt_nxt       = target;
                dvd_nxt       = target - origin_r;
                rem_nxt       = '0;
                cnt_nxt       = CW'(TW - 1);
                state_nxt     = ST_DIV;
              end else begin
                origin_nxt             = origin_r + iv_t;
                out_data_nxt.ready_res = 1'b1;
              end
            end
            CMD_START: begin
              if (iv_t == '0) begin
                if (running_r) begin
                  running_nxt = 1'b0;
                  paused_nxt  = elapsed;
                end
              end else begin
                running_nxt = 1'b1;
                just_nxt    = fire_r;
                origin_nxt  = now_t;
              end
            end
            CMD_STOP: begin
              if (running_r) begin
                running_nxt = 1'b0;
                paused_nxt  = elapsed;
              end
            end
            CMD_RESUME: begin
              if (!running_r) begin
                running_nxt = 1'b1;
                just_nxt    = fire_r;
                origin_nxt  = now_t - paused_r;
              end
            end
            CMD_ORIGIN: begin
              origin_nxt = now_t;
            end
            default: ;
          endcase
          out_data_nxt.enabled = running_nxt;
        end
      end
      ST_DIV: begin
        // One restoring division step per cycle.
        if (shifted >= {1'b0, iv_t}) begin
          rem_nxt = TW'(shifted - {1'b0, iv_t});
        end else begin
          rem_nxt = shifted[TW-1:0];
        end
        dvd_nxt = {dvd_r[TW-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_ADJ;
        end
      end
      ST_ADJ: begin
        // Distance from the target up to the next whole period.
        if (rem_r != '0) begin
          rem_nxt = iv_t - rem_r;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Commit the new origin once the output register is free.
        if (out_free) begin
          origin_nxt             = tgt_r + rem_r;
          out_valid_nxt          = 1'b1;
          out_data_nxt.ready_res = 1'b1;
          out_data_nxt.enabled   = running_r;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
